// File: src/fxa_pkg.sv
// ----------------------------------------------------------------------------
// fxa_pkg
// Types, action codes and helpers shared by the fixed-point ALU files.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int REM_W = 65;

  localparam logic [3:0] ACT_ADD      = 4'd0;
  localparam logic [3:0] ACT_SUB      = 4'd1;
  localparam logic [3:0] ACT_MUL      = 4'd2;
  localparam logic [3:0] ACT_DIV      = 4'd3;
  localparam logic [3:0] ACT_GT       = 4'd4;
  localparam logic [3:0] ACT_LT       = 4'd5;
  localparam logic [3:0] ACT_GE       = 4'd6;
  localparam logic [3:0] ACT_LE       = 4'd7;
  localparam logic [3:0] ACT_EQ       = 4'd8;
  localparam logic [3:0] ACT_NE       = 4'd9;
  localparam logic [3:0] ACT_MIN      = 4'd10;
  localparam logic [3:0] ACT_MAX      = 4'd11;
  localparam logic [3:0] ACT_INC      = 4'd12;
  localparam logic [3:0] ACT_DEC      = 4'd13;
  localparam logic [3:0] ACT_TO_INT   = 4'd14;
  localparam logic [3:0] ACT_FROM_INT = 4'd15;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fxa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } fxa_out_t;

  typedef struct packed {
    logic               valid;
    logic               is_div;
    logic               div_zero;
    logic               neg;
    logic               a_neg;
    logic               ovf;
    logic [REM_W-1:0]   rem;
    logic [32:0]        den;
    logic [31:0]        quo;
    fxa_out_t           base;
  } fxa_div_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } fxa_sat_t;

  function automatic fxa_sat_t signed_mag(input logic neg, input logic [64:0] mag);
    fxa_sat_t r;
    r.ovf = 1'b0;
    r.val = '0;
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        r.ovf = 1'b1;
        r.val = VAL_MIN;
      end else begin
        r.val = -$signed(mag[31:0]);
      end
    end else begin
      if (mag > 65'h0_7FFF_FFFF) begin
        r.ovf = 1'b1;
        r.val = VAL_MAX;
      end else begin
        r.val = $signed(mag[31:0]);
      end
    end
    return r;
  endfunction

endpackage

// File: src/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits, saturating.
//
//   channel  | ports                  | transfer
//   ---------+------------------------+-------------------------------
//   request  | start, busy, req_i     | start high while busy low
//   result   | done_o, res_o          | done_o high for one cycle
//
// Every action passes through the stage 0, stage 1 and stage 2 registers,
// the 32 one-bit stages of the divider and the output register.
// One item may enter in every cycle; busy stays low.
// Reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  fxa_pkg::fxa_in_t  req_i,
  output logic              busy,
  output logic              done_o,
  output fxa_pkg::fxa_out_t res_o
);
  import fxa_pkg::*;

  localparam logic [65:0] HALF = 66'((64'd1 << FRAC_BITS) >> 1);

  // stage 0
  logic        s0_valid_q;
  fxa_in_t     s0_req_q;
  logic [31:0] s0_ma_q, s0_mb_q;
  logic [31:0] ma_d, mb_d;

  // stage 1
  logic        s1_valid_q;
  logic [3:0]  s1_action_q;
  fxa_out_t    s1_base_q, base_d;
  logic [63:0] s1_prod_q;
  logic [64:0] s1_num_q;
  logic [32:0] s1_den_q;
  logic        s1_neg_q, s1_aneg_q, s1_bzero_q;

  logic signed [31:0] a, b;
  logic [32:0]        sum_add, sum_sub, sum_inc, sum_dec;
  logic signed [63:0] from_ext, from_sh;

  // stage 2 and divider
  fxa_div_t div_d;
  fxa_div_t s2_q;
  logic     s2_valid_q;
  fxa_div_t chain [0:32];
  logic [65:0] mul_rnd;
  fxa_sat_t    mul_sat, div_sat;

  // output
  logic     done_q;
  fxa_out_t res_q, res_d;

  function automatic fxa_out_t sat33(input logic [32:0] s);
    fxa_out_t r;
    r.compare_true = 1'b0;
    r.status       = ST_OK;
    r.result_value = $signed(s[31:0]);
    if (s[32] != s[31]) begin
      r.status       = ST_OVF;
      r.result_value = s[32] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

  assign busy = 1'b0;

  assign ma_d = req_i.operand_a[31] ? 32'(-req_i.operand_a) : 32'(req_i.operand_a);
  assign mb_d = req_i.operand_b[31] ? 32'(-req_i.operand_b) : 32'(req_i.operand_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s0_valid_q <= start & ~busy;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      done_q     <= chain[32].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_req_q <= req_i;
    s0_ma_q  <= ma_d;
    s0_mb_q  <= mb_d;
  end

  always_comb begin
    a        = s0_req_q.operand_a;
    b        = s0_req_q.operand_b;
    sum_add  = {a[31], a} + {b[31], b};
    sum_sub  = {a[31], a} - {b[31], b};
    sum_inc  = {a[31], a} + 33'd1;
    sum_dec  = {a[31], a} - 33'd1;
    from_ext = {{32{a[31]}}, a};
    from_sh  = from_ext <<< FRAC_BITS;
    base_d   = '0;
    unique case (s0_req_q.action)
      ACT_ADD:      base_d = sat33(sum_add);
      ACT_SUB:      base_d = sat33(sum_sub);
      ACT_MUL:      base_d = '0;
      ACT_DIV:      base_d = '0;
      ACT_GT:       base_d.compare_true = a > b;
      ACT_LT:       base_d.compare_true = a < b;
      ACT_GE:       base_d.compare_true = a >= b;
      ACT_LE:       base_d.compare_true = a <= b;
      ACT_EQ:       base_d.compare_true = a == b;
      ACT_NE:       base_d.compare_true = a != b;
      ACT_MIN:      base_d.result_value = (a > b) ? b : a;
      ACT_MAX:      base_d.result_value = (a > b) ? a : b;
      ACT_INC:      base_d = sat33(sum_inc);
      ACT_DEC:      base_d = sat33(sum_dec);
      ACT_TO_INT:   base_d.result_value = a >>> FRAC_BITS;
      ACT_FROM_INT: begin
        if ((&from_sh[63:31]) | ~(|from_sh[63:31])) begin
          base_d.result_value = from_sh[31:0];
        end else begin
          base_d.status       = ST_OVF;
          base_d.result_value = a[31] ? VAL_MIN : VAL_MAX;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    s1_action_q <= s0_req_q.action;
    s1_base_q   <= base_d;
    s1_prod_q   <= s0_ma_q * s0_mb_q;
    s1_num_q    <= (65'(s0_ma_q) << (FRAC_BITS + 1)) + 65'(s0_mb_q);
    s1_den_q    <= {s0_mb_q, 1'b0};
    s1_neg_q    <= s0_req_q.operand_a[31] ^ s0_req_q.operand_b[31];
    s1_aneg_q   <= s0_req_q.operand_a[31];
    s1_bzero_q  <= (s0_mb_q == 32'd0);
  end

  always_comb begin
    mul_rnd = (66'(s1_prod_q) + HALF) >> FRAC_BITS;
    mul_sat = signed_mag(s1_neg_q, mul_rnd[64:0]);
    div_d          = '0;
    div_d.is_div   = (s1_action_q == ACT_DIV);
    div_d.div_zero = s1_bzero_q;
    div_d.neg      = s1_neg_q;
    div_d.a_neg    = s1_aneg_q;
    div_d.ovf      = s1_num_q >= (REM_W'(s1_den_q) << 32);
    div_d.rem      = s1_num_q;
    div_d.den      = s1_den_q;
    div_d.base     = s1_base_q;
    if (s1_action_q == ACT_MUL) begin
      div_d.base.result_value = mul_sat.val;
      div_d.base.status       = mul_sat.ovf ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= div_d;
  end

  always_comb begin
    chain[0]       = s2_q;
    chain[0].valid = s2_valid_q;
  end

  for (genvar i = 0; i < 32; i++) begin : g_div
    fxa_div_stage #(
      .BIT(31 - i)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .in_i  (chain[i]),
      .out_o (chain[i+1])
    );
  end

  always_comb begin
    div_sat = signed_mag(chain[32].neg,
                         chain[32].ovf ? 65'h2_0000_0000 : 65'(chain[32].quo));
    res_d   = chain[32].base;
    if (chain[32].is_div) begin
      res_d.compare_true = 1'b0;
      if (chain[32].div_zero) begin
        res_d.result_value = chain[32].a_neg ? VAL_MIN : VAL_MAX;
        res_d.status       = ST_DIVZ;
      end else begin
        res_d.result_value = div_sat.val;
        res_d.status       = div_sat.ovf ? ST_OVF : ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.status == ST_OK || res_o.status == ST_OVF ||
                res_o.status == ST_DIVZ))
    else $error("bad status code");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.compare_true) |-> (res_o.result_value == 0 && res_o.status == ST_OK))
    else $error("compare result carries value or status");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != ST_OK) |->
      (res_o.result_value == VAL_MAX || res_o.result_value == VAL_MIN))
    else $error("flagged result not saturated");

endmodule

// File: src/fxa_div_stage.sv
// ----------------------------------------------------------------------------
// fxa_div_stage
// One restoring-division step: resolves one quotient bit, registered.
// ----------------------------------------------------------------------------
module fxa_div_stage #(
  parameter int BIT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fxa_pkg::fxa_div_t in_i,
  output fxa_pkg::fxa_div_t out_o
);
  import fxa_pkg::*;

  logic [REM_W-1:0] den_sh;
  logic [REM_W:0]   diff;
  logic             take;
  fxa_div_t         nxt;
  logic             valid_q;
  fxa_div_t         data_q;

  always_comb begin
    den_sh = REM_W'(in_i.den) << BIT;
    diff   = {1'b0, in_i.rem} - {1'b0, den_sh};
    take   = ~diff[REM_W];
    nxt    = in_i;
    if (take) begin
      nxt.rem = diff[REM_W-1:0];
    end
    nxt.quo[BIT] = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= nxt;
  end

  always_comb begin
    out_o       = data_q;
    out_o.valid = valid_q;
  end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point ALU: directed corner operands for
// every action, then random and boundary-biased operands, under several
// request-gap phases; each result is checked against an exact predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import fxa_pkg::*;

  localparam int FB = 8;
  localparam int LATENCY = 36;

  class alu_scoreboard;
    fxa_out_t pending_q[$];
    int errors;

    function automatic logic signed [31:0] clamp(input logic signed [65:0] v,
                                                 inout logic [1:0] st);
      if (v > 66'sd2147483647) begin
        st = ST_OVF;
        return VAL_MAX;
      end
      if (v < -66'sd2147483648) begin
        st = ST_OVF;
        return VAL_MIN;
      end
      return v[31:0];
    endfunction

    function automatic fxa_out_t compute(fxa_in_t req);
      fxa_out_t o;
      logic signed [65:0] a, b, mag, ma, mb, mask;
      logic neg;
      a = 66'(req.operand_a);
      b = 66'(req.operand_b);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      neg = (a < 0) != (b < 0);
      mask = (66'sd1 <<< FB) - 1;
      o = '0;
      o.status = ST_OK;
      case (req.action)
        ACT_ADD: o.result_value = clamp(a + b, o.status);
        ACT_SUB: o.result_value = clamp(a - b, o.status);
        ACT_MUL: begin
          mag = (ma * mb + ((66'sd1 <<< FB) >>> 1)) >>> FB;
          o.result_value = clamp(neg ? -mag : mag, o.status);
        end
        ACT_DIV: begin
          if (b == 0) begin
            o.status = ST_DIVZ;
            o.result_value = a < 0 ? VAL_MIN : VAL_MAX;
          end else begin
            mag = (2 * (ma <<< FB) + mb) / (2 * mb);
            o.result_value = clamp(neg ? -mag : mag, o.status);
          end
        end
        ACT_GT: o.compare_true = a > b;
        ACT_LT: o.compare_true = a < b;
        ACT_GE: o.compare_true = a >= b;
        ACT_LE: o.compare_true = a <= b;
        ACT_EQ: o.compare_true = a == b;
        ACT_NE: o.compare_true = a != b;
        ACT_MIN: o.result_value = a > b ? b[31:0] : a[31:0];
        ACT_MAX: o.result_value = a > b ? a[31:0] : b[31:0];
        ACT_INC: o.result_value = clamp(a + 1, o.status);
        ACT_DEC: o.result_value = clamp(a - 1, o.status);
        ACT_TO_INT: begin
          mag = a < 0 ? -((ma + mask) >>> FB) : (ma >>> FB);
          o.result_value = mag[31:0];
        end
        default: begin
          mag = ma <<< FB;
          o.result_value = clamp(a < 0 ? -mag : mag, o.status);
        end
      endcase
      return o;
    endfunction

    function void note_request(fxa_in_t req);
      pending_q.push_back(compute(req));
    endfunction

    function void check_result(fxa_out_t got);
      fxa_out_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.result_value !== exp_r.result_value) begin
        $error("result_value exp %0d got %0d", exp_r.result_value, got.result_value);
        errors++;
      end
      if (got.compare_true !== exp_r.compare_true) begin
        $error("compare_true exp %0d got %0d", exp_r.compare_true, got.compare_true);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status exp %0d got %0d", exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  fxa_in_t  req_i;
  logic     busy;
  logic     done_o;
  fxa_out_t res_o;
  int       idle_pct;
  alu_scoreboard sb;

  fixed_point_alu_q24_8 #(.FRAC_BITS(FB)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_request(req_i);
      if (done_o) sb.check_result(res_o);
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return VAL_MAX - $urandom_range(0, 2);
      1: return VAL_MIN + $urandom_range(0, 2);
      2: return $urandom_range(0, 3) - 1;
      3: return $signed($urandom_range(0, 4096)) - 2048;
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      5: return ($urandom_range(0, 1) ? 32'h0080_0000 : 32'hFF80_0000) +
                $urandom_range(0, 3) - 1;
      default: return $urandom;
    endcase
  endfunction

  // hold start high across back-to-back transfers; drop it only for gaps
  task automatic send(input logic [3:0] act, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{action: act, operand_a: a, operand_b: b};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  logic [31:0] edge_vals [8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1,
                                 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF00, 32'h0080_0000};

  initial begin
    sb = new();
    start = 1'b0;
    req_i = '0;
    idle_pct = 0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 16; i++)
      send(i[3:0], edge_vals[i % 8], edge_vals[(i * 3 + 1) % 8]);
    send(ACT_DIV, 32'h0, 32'h0);
    send(ACT_DIV, 32'h8000_0000, 32'h0);
    send(ACT_DIV, 32'h7FFF_FFFF, 32'h1);
    send(ACT_MUL, 32'h8000_0000, 32'h8000_0000);
    send(ACT_MUL, 32'h8000_0000, 32'h100);
    send(ACT_INC, 32'h7FFF_FFFF, 32'h0);
    send(ACT_DEC, 32'h8000_0000, 32'h0);
    send(ACT_TO_INT, 32'hFFFF_FFFF, 32'h0);
    send(ACT_FROM_INT, 32'hFF80_0000, 32'h0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 75 : (ph == 2) ? 11 : 0;
      for (int n = 0; n < 410; n++)
        send(4'($urandom_range(0, 15)), pick_operand(),
             $urandom_range(0, 7) == 0 ? 32'h0 : pick_operand());
    end
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end
endmodule
